FILE: hw/rtl/bpcea_pkg.sv
// shared types and constants of the button press classifier / encoder accumulator
// no dependencies; used by every other file of the block but bpcea_ram

package bpcea_pkg;

   // fixed field widths
   localparam int unsigned CHAN_W  = 2;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned POS_W   = 32;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 2;

   // default channel count
   localparam int unsigned CHANNELS_DEFAULT = 4;

   // response queue depth
   localparam int unsigned RSP_DEPTH = 3;
   localparam int unsigned RSP_PTR_W = 2;
   localparam int unsigned RSP_CNT_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS       = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERY_LONG_PRESS_MS = 2'd2;

   // register reset values
   localparam logic [CSR_W-1:0] DEBOUNCE_MS_RESET        = 16'd50;
   localparam logic [CSR_W-1:0] LONG_PRESS_MS_RESET      = 16'd800;
   localparam logic [CSR_W-1:0] VERY_LONG_PRESS_MS_RESET = 16'd2500;

   // button sample codes
   localparam logic LEVEL_PRESSED  = 1'b0;
   localparam logic LEVEL_RELEASED = 1'b1;

   // per-channel state word kept in the state memory
   typedef struct packed {
      logic              level;
      logic [TIME_W-1:0] last_accept;
      logic [TIME_W-1:0] press_start;
      logic [POS_W-1:0]  position;
   } chan_state_type;

   localparam chan_state_type CHAN_STATE_RESET = '{
      level:       LEVEL_RELEASED,
      last_accept: '0,
      press_start: '0,
      position:    '0
   };

   // one result beat
   typedef struct packed {
      logic [CHAN_W-1:0]       out_channel;
      logic                    short_press;
      logic                    long_press;
      logic                    very_long_press;
      logic                    held;
      logic [TIME_W-1:0]       press_start_ms;
      logic signed [POS_W-1:0] position;
      logic                    changed;
   } rsp_payload_type;

endpackage

FILE: hw/rtl/bpcea_if.sv
// valid/ready channel interfaces for poll beats and result beats
// depends on bpcea_pkg

interface bpcea_req_if;
   logic                                valid;
   logic                                ready;
   logic [bpcea_pkg::CHAN_W-1:0]        channel;
   logic                                level;
   logic                                confirm_level;
   logic signed [bpcea_pkg::POS_W-1:0]  delta;
   logic [bpcea_pkg::TIME_W-1:0]        now_ms;

   modport source (output valid, channel, level, confirm_level, delta, now_ms,
                   input ready);
   modport sink   (input valid, channel, level, confirm_level, delta, now_ms,
                   output ready);
endinterface

interface bpcea_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [bpcea_pkg::CHAN_W-1:0]        out_channel;
   logic                                short_press;
   logic                                long_press;
   logic                                very_long_press;
   logic                                held;
   logic [bpcea_pkg::TIME_W-1:0]        press_start_ms;
   logic signed [bpcea_pkg::POS_W-1:0]  position;
   logic                                changed;

   modport source (output valid, out_channel, short_press, long_press, very_long_press,
                   held, press_start_ms, position, changed,
                   input ready);
   modport sink   (input valid, out_channel, short_press, long_press, very_long_press,
                   held, press_start_ms, position, changed,
                   output ready);
endinterface

FILE: hw/rtl/bpcea_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module bpcea_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: hw/rtl/button_press_classifier_encoder_accum_core.sv
// top level of the button press classifier with encoder accumulator
// depends on bpcea_pkg, bpcea_if (bpcea_req_if, bpcea_rsp_if) and bpcea_ram
//
//   channel  | dir | handshake      | beat contents
//   ---------+-----+----------------+-------------------------------------------------
//   req_ch   | in  | valid / ready  | channel, level, confirm_level, delta, now_ms
//   rsp_ch   | out | valid / ready  | out_channel, press pulses, held, press_start_ms,
//            |     |                | position, changed
//   csr_*    | in  | write enable   | csr_index selects register, csr_wdata is the value
//
// one poll beat is accepted per cycle while req_ready is high; each produces
// exactly one result beat, queued after the state ram read and classify / write back
// the per-channel state sits in one ram; a one-entry write-back register forwards
// the newest state when back-to-back polls hit the same channel
// reset is synchronous; entry valid flags make an unwritten channel read as its
// reset state, so no clearing pass is needed
// a three-beat result queue absorbs rsp stalls; req_ready drops only when the
// queue plus the item in flight already fill it

module button_press_classifier_encoder_accum_core #(
   parameter int unsigned CHANNELS = bpcea_pkg::CHANNELS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bpcea_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bpcea_pkg::CSR_W-1:0]       csr_wdata,
   bpcea_req_if.sink                         req_ch,
   bpcea_rsp_if.source                       rsp_ch
);

   localparam int unsigned AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CWIDE  = AW + bpcea_pkg::CHAN_W;
   localparam int unsigned STATE_W = $bits(bpcea_pkg::chan_state_type);

   // ---------------- configuration registers ----------------
   logic [bpcea_pkg::CSR_W-1:0] debounce_ms_ff, debounce_ms_in;
   logic [bpcea_pkg::CSR_W-1:0] long_ms_ff, long_ms_in;
   logic [bpcea_pkg::CSR_W-1:0] very_long_ms_ff, very_long_ms_in;

   always_comb begin
      debounce_ms_in  = debounce_ms_ff;
      long_ms_in      = long_ms_ff;
      very_long_ms_in = very_long_ms_ff;
      if (csr_we) begin
         case (csr_index)
            bpcea_pkg::CSR_DEBOUNCE_MS:        debounce_ms_in  = csr_wdata;
            bpcea_pkg::CSR_LONG_PRESS_MS:      long_ms_in      = csr_wdata;
            bpcea_pkg::CSR_VERY_LONG_PRESS_MS: very_long_ms_in = csr_wdata;
            default: ;  // unknown index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff  <= bpcea_pkg::DEBOUNCE_MS_RESET;
         long_ms_ff      <= bpcea_pkg::LONG_PRESS_MS_RESET;
         very_long_ms_ff <= bpcea_pkg::VERY_LONG_PRESS_MS_RESET;
      end else begin
         debounce_ms_ff  <= debounce_ms_in;
         long_ms_ff      <= long_ms_in;
         very_long_ms_ff <= very_long_ms_in;
      end
   end

   // ---------------- stage 0: accept and issue ram read ----------------
   logic                  req_accept;
   logic [CWIDE-1:0]      req_ch_wide;
   logic [AW-1:0]         req_addr;
   logic                  req_in_range;

   assign req_accept   = req_ch.valid && req_ch.ready;
   assign req_ch_wide  = {{AW{1'b0}}, req_ch.channel};
   assign req_addr     = req_ch_wide[AW-1:0];
   assign req_in_range = req_ch_wide < CWIDE'(CHANNELS);

   // stage 1 registers: control reset, payload not
   logic                                s1_valid_ff, s1_valid_in;
   logic                                s1_in_range_ff;
   logic [AW-1:0]                       s1_addr_ff;
   logic [bpcea_pkg::CHAN_W-1:0]        s1_channel_ff;
   logic                                s1_level_ff;
   logic                                s1_confirm_ff;
   logic [bpcea_pkg::POS_W-1:0]         s1_delta_ff;
   logic [bpcea_pkg::TIME_W-1:0]        s1_now_ff;

   assign s1_valid_in = req_accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_in_range_ff <= req_in_range;
         s1_addr_ff     <= req_addr;
         s1_channel_ff  <= req_ch.channel;
         s1_level_ff    <= req_ch.level;
         s1_confirm_ff  <= req_ch.confirm_level;
         s1_delta_ff    <= $unsigned(req_ch.delta);
         s1_now_ff      <= req_ch.now_ms;
      end
   end

   // ---------------- state ram ----------------
   logic                  st_we;
   logic [STATE_W-1:0]    st_wdata;
   logic [STATE_W-1:0]    st_rdata;

   bpcea_ram #(
      .WIDTH (STATE_W),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock (clock),
      .we    (st_we),
      .waddr (s1_addr_ff),
      .wdata (st_wdata),
      .re    (req_accept),
      .raddr (req_addr),
      .rdata (st_rdata)
   );

   // entry valid flags: a never-written channel reads as its reset state
   logic [CHANNELS-1:0] entry_valid_ff, entry_valid_in;

   always_comb begin
      entry_valid_in = entry_valid_ff;
      if (st_we) begin
         entry_valid_in[s1_addr_ff] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   // write-back forwarding register: newest state written
   logic                       fwd_valid_ff;
   logic [AW-1:0]              fwd_addr_ff;
   bpcea_pkg::chan_state_type  fwd_state_ff;

   // ---------------- stage 1: classify, accumulate, write back ----------------
   bpcea_pkg::chan_state_type cur_state;
   bpcea_pkg::chan_state_type new_state;
   logic [bpcea_pkg::TIME_W-1:0] since_accept;
   logic [bpcea_pkg::TIME_W-1:0] press_len;
   logic                         edge_seen;
   logic                         edge_ok;
   logic                         release_ok;
   logic                         pulse_very_long;
   logic                         pulse_long;
   logic                         pulse_short;
   bpcea_pkg::rsp_payload_type   s1_rsp;

   always_comb begin
      // newest state: forwarded write, then ram, then reset value
      if (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) begin
         cur_state = fwd_state_ff;
      end else if (entry_valid_ff[s1_addr_ff]) begin
         cur_state = bpcea_pkg::chan_state_type'(st_rdata);
      end else begin
         cur_state = bpcea_pkg::CHAN_STATE_RESET;
      end

      // wrapping time differences
      since_accept = s1_now_ff - cur_state.last_accept;
      press_len    = s1_now_ff - cur_state.press_start;

      edge_seen = s1_level_ff != cur_state.level;
      edge_ok   = edge_seen && (s1_confirm_ff == s1_level_ff) &&
                  (since_accept >= {{(bpcea_pkg::TIME_W-bpcea_pkg::CSR_W){1'b0}},
                                    debounce_ms_ff});
      release_ok = edge_ok && (s1_level_ff == bpcea_pkg::LEVEL_RELEASED);

      // very long is tested first, so it wins when thresholds overlap
      pulse_very_long = release_ok &&
                        (press_len >= {{(bpcea_pkg::TIME_W-bpcea_pkg::CSR_W){1'b0}},
                                       very_long_ms_ff});
      pulse_long      = release_ok && !pulse_very_long &&
                        (press_len >= {{(bpcea_pkg::TIME_W-bpcea_pkg::CSR_W){1'b0}},
                                       long_ms_ff});
      pulse_short     = release_ok && !pulse_very_long && !pulse_long;

      new_state = cur_state;
      if (edge_ok) begin
         new_state.level       = s1_level_ff;
         new_state.last_accept = s1_now_ff;
         if (s1_level_ff == bpcea_pkg::LEVEL_PRESSED) begin
            new_state.press_start = s1_now_ff;
         end
      end
      new_state.position = cur_state.position + s1_delta_ff;

      // result beat; out-of-range channel gives zeros except the channel
      s1_rsp = '0;
      s1_rsp.out_channel = s1_channel_ff;
      if (s1_in_range_ff) begin
         s1_rsp.short_press     = pulse_short;
         s1_rsp.long_press      = pulse_long;
         s1_rsp.very_long_press = pulse_very_long;
         s1_rsp.held            = new_state.level == bpcea_pkg::LEVEL_PRESSED;
         s1_rsp.press_start_ms  = new_state.press_start;
         s1_rsp.position        = $signed(new_state.position);
         s1_rsp.changed         = pulse_short || pulse_long || pulse_very_long ||
                                  (s1_level_ff != new_state.level) ||
                                  (s1_delta_ff != '0);
      end
   end

   assign st_we    = s1_valid_ff && s1_in_range_ff;
   assign st_wdata = new_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (st_we) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         fwd_addr_ff  <= s1_addr_ff;
         fwd_state_ff <= new_state;
      end
   end

   // ---------------- result queue ----------------
   bpcea_pkg::rsp_payload_type       rsp_q_ff [bpcea_pkg::RSP_DEPTH];
   logic [bpcea_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bpcea_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [bpcea_pkg::RSP_CNT_W-1:0]  count_ff, count_in;
   logic                             q_push;
   logic                             q_pop;
   logic [bpcea_pkg::RSP_CNT_W:0]    occupancy;
   bpcea_pkg::rsp_payload_type       rsp_head;

   assign q_push = s1_valid_ff;
   assign q_pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == bpcea_pkg::RSP_PTR_W'(bpcea_pkg::RSP_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == bpcea_pkg::RSP_PTR_W'(bpcea_pkg::RSP_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({q_push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         rsp_q_ff[wr_ptr_ff] <= s1_rsp;
      end
   end

   // room for the beat in flight plus one more
   assign occupancy    = {1'b0, count_ff} + {{bpcea_pkg::RSP_CNT_W{1'b0}}, s1_valid_ff};
   assign req_ch.ready = occupancy < (bpcea_pkg::RSP_CNT_W + 1)'(bpcea_pkg::RSP_DEPTH);

   assign rsp_head               = rsp_q_ff[rd_ptr_ff];
   assign rsp_ch.valid           = count_ff != '0;
   assign rsp_ch.out_channel     = rsp_head.out_channel;
   assign rsp_ch.short_press     = rsp_head.short_press;
   assign rsp_ch.long_press      = rsp_head.long_press;
   assign rsp_ch.very_long_press = rsp_head.very_long_press;
   assign rsp_ch.held            = rsp_head.held;
   assign rsp_ch.press_start_ms  = rsp_head.press_start_ms;
   assign rsp_ch.position        = rsp_head.position;
   assign rsp_ch.changed         = rsp_head.changed;

endmodule

FILE: hw/rtl/bpcea_chk.sv
// port-level checker for the button press classifier / encoder accumulator
// depends on bpcea_pkg; bound to button_press_classifier_encoder_accum_core

module bpcea_chk (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [bpcea_pkg::CHAN_W-1:0]      rsp_out_channel,
   input logic                              rsp_short_press,
   input logic                              rsp_long_press,
   input logic                              rsp_very_long_press,
   input logic                              rsp_held,
   input logic [bpcea_pkg::TIME_W-1:0]      rsp_press_start_ms,
   input logic signed [bpcea_pkg::POS_W-1:0] rsp_position,
   input logic                              rsp_changed
);

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid &&
         $stable(rsp_out_channel) && $stable(rsp_position) &&
         $stable(rsp_press_start_ms) && $stable(rsp_changed))
      else $error("stalled result beat changed");

   // every accepted poll has a result waiting once the ram read and classify stages are done
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> ##2 rsp_valid)
      else $error("accepted poll produced no result");

   // at most one press class per result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_short_press, rsp_long_press, rsp_very_long_press}))
      else $error("more than one press class reported");

   // a press class comes only with a release, and marks the beat changed
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_short_press || rsp_long_press || rsp_very_long_press)
         |-> !rsp_held && rsp_changed)
      else $error("press class without release");

   // nothing is shown right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind button_press_classifier_encoder_accum_core bpcea_chk u_bpcea_chk (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_out_channel     (rsp_ch.out_channel),
   .rsp_short_press     (rsp_ch.short_press),
   .rsp_long_press      (rsp_ch.long_press),
   .rsp_very_long_press (rsp_ch.very_long_press),
   .rsp_held            (rsp_ch.held),
   .rsp_press_start_ms  (rsp_ch.press_start_ms),
   .rsp_position        (rsp_ch.position),
   .rsp_changed         (rsp_ch.changed)
);

FILE: test/tb.sv
// self-checking bench for button_press_classifier_encoder_accum_core: polls go in on req_ch,
// result beats are checked field by field against a tracker of the per-channel button state
// depends on bpcea_pkg, bpcea_if (bpcea_req_if, bpcea_rsp_if) and the core itself

module tb;
   import bpcea_pkg::*;

   localparam int unsigned NUM_CH          = CHANNELS_DEFAULT;
   localparam int unsigned CLOCK_PERIOD    = 8;
   localparam int unsigned CYCLE_LIMIT     = 600000;
   localparam int unsigned PHASE_COUNT     = 7;
   localparam int unsigned ITEMS_PER_PHASE = 200;
   localparam int unsigned HOLD_OFF_ITEMS  = 60;
   localparam int unsigned HOLD_OFF_CYCLES = 250;
   localparam int unsigned SETTLE_CYCLES   = 6;
   localparam int unsigned MAX_REPORTS     = 40;
   // index 3 decodes to no register, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // one poll beat as the sender builds it
   typedef struct packed {
      logic [CHAN_W-1:0]       channel;
      logic                    level;
      logic                    confirm_level;
      logic signed [POS_W-1:0] delta;
      logic [TIME_W-1:0]       now_ms;
   } poll_beat_type;

   // per-channel debounce / press timing / encoder state plus the results still owed
   class button_tracker;
      logic [CSR_W-1:0]  lockout_ms;
      logic [CSR_W-1:0]  long_ms;
      logic [CSR_W-1:0]  very_long_ms;
      logic              level_q [NUM_CH];
      logic [TIME_W-1:0] last_accept_q [NUM_CH];
      logic [TIME_W-1:0] press_start_q [NUM_CH];
      logic [POS_W-1:0]  position_q [NUM_CH];
      rsp_payload_type   due_results [$];
      int unsigned       errors, polls, checked, shorts, longs, very_longs, rejected_edges;

      function new();
         lockout_ms   = DEBOUNCE_MS_RESET;
         long_ms      = LONG_PRESS_MS_RESET;
         very_long_ms = VERY_LONG_PRESS_MS_RESET;
         for (int c = 0; c < NUM_CH; c++) begin
            level_q[c]       = LEVEL_RELEASED;
            last_accept_q[c] = '0;
            press_start_q[c] = '0;
            position_q[c]    = '0;
         end
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            CSR_DEBOUNCE_MS:        lockout_ms   = val;
            CSR_LONG_PRESS_MS:      long_ms      = val;
            CSR_VERY_LONG_PRESS_MS: very_long_ms = val;
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction

      function void note_poll(poll_beat_type p);
         rsp_payload_type want;
         logic [TIME_W-1:0] since, dur;
         int unsigned c;
         bit accept;
         want = '0;
         want.out_channel = p.channel;
         c = p.channel;
         polls++;
         if (c >= NUM_CH) begin
            due_results.push_back(want);
            return;
         end
         since  = p.now_ms - last_accept_q[c];
         accept = (p.level != level_q[c]) && (p.confirm_level == p.level) &&
                  (since >= TIME_W'(lockout_ms));
         if (p.level != level_q[c] && !accept)
            rejected_edges++;
         if (accept) begin
            last_accept_q[c] = p.now_ms;
            level_q[c]       = p.level;
            if (p.level == LEVEL_PRESSED) begin
               press_start_q[c] = p.now_ms;
            end else begin
               // very long is tested first, so it wins when its threshold is the lower one
               dur = p.now_ms - press_start_q[c];
               if (dur >= TIME_W'(very_long_ms))
                  want.very_long_press = 1'b1;
               else if (dur >= TIME_W'(long_ms))
                  want.long_press = 1'b1;
               else
                  want.short_press = 1'b1;
            end
         end
         position_q[c]       = position_q[c] + p.delta;
         want.held           = (level_q[c] == LEVEL_PRESSED);
         want.press_start_ms = press_start_q[c];
         want.position       = position_q[c];
         want.changed        = want.short_press | want.long_press | want.very_long_press |
                               (p.level != level_q[c]) | (p.delta != 0);
         due_results.push_back(want);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: result %0d %s mismatch, expected 0x%0h, actual 0x%0h",
                        $time, checked, field, want, got);
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, actual 0x%0h", $time, got);
            return;
         end
         want = due_results.pop_front();
         compare_field("out_channel",     want.out_channel,     got.out_channel);
         compare_field("short_press",     want.short_press,     got.short_press);
         compare_field("long_press",      want.long_press,      got.long_press);
         compare_field("very_long_press", want.very_long_press, got.very_long_press);
         compare_field("held",            want.held,            got.held);
         compare_field("press_start_ms",  want.press_start_ms,  got.press_start_ms);
         compare_field("position",        want.position,        got.position);
         compare_field("changed",         want.changed,         got.changed);
         shorts     += want.short_press;
         longs      += want.long_press;
         very_longs += want.very_long_press;
         checked++;
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   bpcea_req_if req_ch ();
   bpcea_rsp_if rsp_ch ();

   button_press_classifier_encoder_accum_core #(
      .CHANNELS (NUM_CH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   button_tracker     buttons;
   logic [TIME_W-1:0] chan_clock [NUM_CH];   // last timestamp sent per channel
   bit                sender_idle;           // random gaps between poll beats
   int unsigned       hold_off_asked;        // written by stimulus only
   int unsigned       hold_off_done;         // written by result receiver only
   int unsigned       settings_applied;
   int unsigned       cycle_count = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // run-away guard, sized well past the slowest legal run
   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("%0t: timeout after %0d cycles, %0d results still due",
               $time, cycle_count, buttons.pending());
      $display("FAILURE");
      $finish;
   end

   // result monitor: sample pre-edge values, so order within the step does not matter
   always @(posedge clock) begin : result_monitor
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.out_channel     = rsp_ch.out_channel;
         got.short_press     = rsp_ch.short_press;
         got.long_press      = rsp_ch.long_press;
         got.very_long_press = rsp_ch.very_long_press;
         got.held            = rsp_ch.held;
         got.press_start_ms  = rsp_ch.press_start_ms;
         got.position        = rsp_ch.position;
         got.changed         = rsp_ch.changed;
         buttons.check_result(got);
      end
   end

   // result receiver: bursts of full rate, light and heavy stalls, and the long hold-off
   initial begin : result_receiver
      int unsigned span, mode, k, stall;
      rsp_ch.ready = 1'b0;
      forever begin
         span = $urandom_range(16, 128);
         mode = $urandom_range(0, 9);
         for (k = 0; k < span; k++) begin
            @(posedge clock);
            if (hold_off_done != hold_off_asked) begin
               // result queue fills up, req_ready has to drop while polls keep coming
               rsp_ch.ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off_done++;
               rsp_ch.ready <= 1'b1;
            end else if (mode < 4) begin
               rsp_ch.ready <= 1'b1;
            end else if (mode < 8) begin
               rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            end else if ($urandom_range(0, 19) == 0) begin
               stall = $urandom_range(8, 40);
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
               rsp_ch.ready <= 1'b1;
            end else begin
               rsp_ch.ready <= 1'($urandom_range(0, 1));
            end
         end
      end
   end

   // offer one poll beat, note it on acceptance, then maybe idle
   task automatic send_poll(input poll_beat_type p);
      int unsigned r, gap;
      req_ch.valid         <= 1'b1;
      req_ch.channel       <= p.channel;
      req_ch.level         <= p.level;
      req_ch.confirm_level <= p.confirm_level;
      req_ch.delta         <= p.delta;
      req_ch.now_ms        <= p.now_ms;
      do @(posedge clock); while (!req_ch.ready);
      buttons.note_poll(p);
      gap = 0;
      if (sender_idle) begin
         r = $urandom_range(0, 99);
         if (r >= 92)
            gap = $urandom_range(8, 40);
         else if (r >= 60)
            gap = $urandom_range(1, 3);
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic offer_poll(input int unsigned ch, input logic lvl, input logic conf,
                             input logic signed [POS_W-1:0] delta,
                             input logic [TIME_W-1:0] stamp);
      poll_beat_type p;
      p.channel       = CHAN_W'(ch);
      p.level         = lvl;
      p.confirm_level = conf;
      p.delta         = delta;
      p.now_ms        = stamp;
      send_poll(p);
   endtask

   // wait until every result is in, then let the two-stage pipe settle
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (buttons.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      buttons.write_reg(idx, val);
   endtask

   task automatic apply_settings(input logic [CSR_W-1:0] lockout, long_len, very_long_len,
                                 input bit poke_unused);
      if (poke_unused)
         csr_write(CSR_UNUSED_INDEX, CSR_W'($urandom()));
      csr_write(CSR_DEBOUNCE_MS, lockout);
      csr_write(CSR_LONG_PRESS_MS, long_len);
      csr_write(CSR_VERY_LONG_PRESS_MS, very_long_len);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic signed [POS_W-1:0] random_delta();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return '0;
      else if (r < 80)
         return POS_W'($urandom_range(0, 16)) - 8;
      else if (r < 95)
         return POS_W'($urandom());
      case ($urandom_range(0, 3))
         0:       return 32'h7fff_ffff;
         1:       return 32'h8000_0000;
         2:       return 32'hffff_ffff;
         default: return 32'h0000_0001;
      endcase
   endfunction

   // mostly well-formed press / release pairs timed around the lockout and the two
   // thresholds, mixed with steady polls, glitches, early edges and raw noise
   function automatic poll_beat_type random_poll();
      poll_beat_type     p;
      int unsigned       c, kind;
      logic [TIME_W-1:0] dur;
      logic              cur;
      c    = $urandom_range(0, NUM_CH - 1);
      cur  = buttons.level_q[c];
      kind = $urandom_range(0, 99);
      p.channel       = CHAN_W'(c);
      p.delta         = random_delta();
      p.level         = ~cur;
      p.confirm_level = ~cur;
      if (kind < 50) begin
         if (cur == LEVEL_RELEASED) begin
            // press right at the end of the lockout or somewhat after it
            p.now_ms = buttons.last_accept_q[c] + TIME_W'(buttons.lockout_ms);
            if ($urandom_range(0, 2) != 0)
               p.now_ms = p.now_ms + TIME_W'($urandom_range(1, 2000));
         end else begin
            // release with a length on or near a threshold
            case ($urandom_range(0, 7))
               0: dur = (buttons.long_ms == 0) ? '0 :
                        TIME_W'($urandom_range(0, int'(buttons.long_ms) - 1));
               1: dur = TIME_W'(buttons.long_ms) - 1;
               2: dur = TIME_W'(buttons.long_ms);
               3: dur = TIME_W'(buttons.very_long_ms) - 1;
               4: dur = TIME_W'(buttons.very_long_ms);
               5: dur = TIME_W'(buttons.very_long_ms) + TIME_W'($urandom_range(1, 4000));
               6: dur = TIME_W'($urandom_range(0, 70000));
               default: dur = TIME_W'($urandom());
            endcase
            if (dur < TIME_W'(buttons.lockout_ms))
               dur = TIME_W'(buttons.lockout_ms);
            p.now_ms = buttons.press_start_q[c] + dur;
         end
      end else if (kind < 70) begin
         // steady poll, no edge
         p.level         = cur;
         p.confirm_level = 1'($urandom_range(0, 1));
         p.now_ms        = chan_clock[c] + TIME_W'($urandom_range(0, 300));
      end else if (kind < 80) begin
         // samples disagree
         p.level         = 1'($urandom_range(0, 1));
         p.confirm_level = ~p.level;
         p.now_ms        = chan_clock[c] + TIME_W'($urandom_range(0, 500));
      end else if (kind < 85) begin
         // clean edge still inside the lockout window
         p.now_ms = buttons.last_accept_q[c];
         if (buttons.lockout_ms != 0)
            p.now_ms = p.now_ms + TIME_W'($urandom_range(0, int'(buttons.lockout_ms) - 1));
      end else begin
         p.level         = 1'($urandom_range(0, 1));
         p.confirm_level = 1'($urandom_range(0, 1));
         p.now_ms        = TIME_W'($urandom());
      end
      chan_clock[c] = p.now_ms;
      return p;
   endfunction

   initial begin : stimulus
      int unsigned ph;
      logic [CSR_W-1:0] lockout, long_len, very_long_len;
      buttons = new();
      for (int c = 0; c < NUM_CH; c++)
         chan_clock[c] = '0;
      sender_idle          = 1'b0;
      hold_off_asked       = 0;
      hold_off_done        = 0;
      settings_applied     = 0;
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_DEBOUNCE_MS;
      csr_wdata            = '0;
      req_ch.valid         = 1'b0;
      req_ch.channel       = '0;
      req_ch.level         = LEVEL_RELEASED;
      req_ch.confirm_level = LEVEL_RELEASED;
      req_ch.delta         = '0;
      req_ch.now_ms        = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part on reset settings: lockout 50, long 800, very long 2500
      // press lengths exactly around both thresholds
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 100);
      offer_poll(0, LEVEL_RELEASED, LEVEL_RELEASED, 0, 899);         // 799, short
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 1000);
      offer_poll(0, LEVEL_RELEASED, LEVEL_RELEASED, 0, 1800);        // 800, long
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 2000);
      offer_poll(0, LEVEL_RELEASED, LEVEL_RELEASED, 0, 4499);        // 2499, long
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 5000);
      offer_poll(0, LEVEL_RELEASED, LEVEL_RELEASED, 0, 7500);        // 2500, very long
      // lockout: one ms short of it is rejected, exactly on it is taken
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  5, 7549);
      offer_poll(0, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 7550);
      // glitch on release, then a quiet poll with a stray confirm sample
      offer_poll(0, LEVEL_RELEASED, LEVEL_PRESSED,  0, 9000);
      offer_poll(0, LEVEL_PRESSED,  LEVEL_RELEASED, 0, 9000);
      offer_poll(0, LEVEL_RELEASED, LEVEL_RELEASED, -3, 9100);
      // encoder extremes and position wrap, timestamp extremes
      offer_poll(1, LEVEL_RELEASED, LEVEL_RELEASED, 32'h7fff_ffff, 0);
      offer_poll(1, LEVEL_RELEASED, LEVEL_RELEASED, 32'h0000_0001, 0);
      offer_poll(1, LEVEL_RELEASED, LEVEL_PRESSED,  32'h8000_0000, 32'hffff_ffff);
      offer_poll(1, LEVEL_RELEASED, LEVEL_RELEASED, -1, 5);
      // press just before the timestamp wraps, release after it
      offer_poll(2, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 32'hffff_fff0);
      offer_poll(2, LEVEL_RELEASED, LEVEL_RELEASED, 0, 32'h0000_0300);
      offer_poll(3, LEVEL_PRESSED,  LEVEL_PRESSED,  0, 32'hffff_ffff);
      offer_poll(3, LEVEL_RELEASED, LEVEL_RELEASED, 0, 0);           // lockout across wrap
      offer_poll(3, LEVEL_RELEASED, LEVEL_RELEASED, 0, 100);
      offer_poll(3, LEVEL_RELEASED, LEVEL_RELEASED, 0, 200);         // nothing changes
      offer_poll(2, LEVEL_PRESSED,  LEVEL_RELEASED, 7, 300);
      drain();

      // random phases, one setting each; registers only change while the core is idle
      for (ph = 0; ph < PHASE_COUNT; ph++) begin
         case (ph)
            0: begin lockout = 16'd50;    long_len = 16'd800;   very_long_len = 16'd2500;  end
            1: begin lockout = 16'd0;     long_len = 16'd0;     very_long_len = 16'd0;     end
            2: begin lockout = 16'hffff;  long_len = 16'hffff;  very_long_len = 16'hffff;  end
            3: begin lockout = 16'd20;    long_len = 16'd3000;  very_long_len = 16'd1000;  end
            4: begin
               lockout       = CSR_W'($urandom_range(0, 300));
               long_len      = CSR_W'($urandom_range(1, 4000));
               very_long_len = CSR_W'($urandom());
            end
            5: begin lockout = 16'd100;   long_len = 16'd100;   very_long_len = 16'd100;   end
            default: begin lockout = 16'd1; long_len = 16'd400; very_long_len = 16'hffff; end
         endcase
         apply_settings(lockout, long_len, very_long_len, ph == 0);
         if (ph == 1) begin
            // back-to-back polls against a receiver that holds off for a long time
            sender_idle = 1'b0;
            hold_off_asked++;
            repeat (HOLD_OFF_ITEMS) send_poll(random_poll());
         end
         sender_idle = (ph != 3);
         repeat (ITEMS_PER_PHASE) send_poll(random_poll());
         drain();
      end

      if (buttons.pending() != 0) begin
         buttons.errors++;
         $display("%0t: %0d expected results never arrived", $time, buttons.pending());
      end
      $display("run covered %0d polls under %0d register settings, %0d results checked",
               buttons.polls, settings_applied + 1, buttons.checked);
      $display("presses: %0d short, %0d long, %0d very long; %0d edges rejected",
               buttons.shorts, buttons.longs, buttons.very_longs, buttons.rejected_edges);
      if (buttons.errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
